>>> src/assert_macros.svh
// Assertion macros used by the top-level RTL file of the PID block.
// Depends on a signal named clock and a signal named reset in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

>>> src/pdoc_pkg.sv
// Shared types and constants of the PID controller with deadband and output clamp.
// No dependencies.
package pdoc_pkg;

   localparam int unsigned GAIN_W   = 16;
   localparam int unsigned ILIM_W   = 23;
   localparam int unsigned DZ_W     = 15;
   localparam int unsigned DLIM_W   = 15;
   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned INTEG_W  = 24;
   localparam int unsigned CSR_AW   = 3;
   localparam int unsigned CSR_DW   = 23;

   localparam logic [ILIM_W-1:0] ILIM_RESET = 23'd8388607;
   localparam logic [DZ_W-1:0]   DZ_RESET   = 15'd128;
   localparam logic [DLIM_W-1:0] DLIM_RESET = 15'd12800;

   typedef enum logic [CSR_AW-1:0] {
      REG_GAIN_P    = 3'd0,
      REG_GAIN_I    = 3'd1,
      REG_GAIN_D    = 3'd2,
      REG_INT_LIMIT = 3'd3,
      REG_DEAD_ZONE = 3'd4,
      REG_DRV_LIMIT = 3'd5
   } reg_idx_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] gain_p;
      logic signed [GAIN_W-1:0] gain_i;
      logic signed [GAIN_W-1:0] gain_d;
      logic [ILIM_W-1:0]        integral_limit;
      logic [DZ_W-1:0]          dead_zone;
      logic [DLIM_W-1:0]        drive_limit;
   } cfg_type;

endpackage

>>> src/pdoc_csr.sv
// Configuration register bank of the PID block.
// Depends on pdoc_pkg.
module pdoc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [pdoc_pkg::CSR_AW-1:0]     csr_addr,
   input  logic [pdoc_pkg::CSR_DW-1:0]     csr_wdata,
   output pdoc_pkg::cfg_type               cfg
);
   import pdoc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         // unknown indexes drop the write
         unique case (csr_addr)
            REG_GAIN_P:    cfg_in.gain_p         = $signed(csr_wdata[GAIN_W-1:0]);
            REG_GAIN_I:    cfg_in.gain_i         = $signed(csr_wdata[GAIN_W-1:0]);
            REG_GAIN_D:    cfg_in.gain_d         = $signed(csr_wdata[GAIN_W-1:0]);
            REG_INT_LIMIT: cfg_in.integral_limit = csr_wdata[ILIM_W-1:0];
            REG_DEAD_ZONE: cfg_in.dead_zone      = csr_wdata[DZ_W-1:0];
            REG_DRV_LIMIT: cfg_in.drive_limit    = csr_wdata[DLIM_W-1:0];
            default:       cfg_in                = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p         <= '0;
         cfg_ff.gain_i         <= '0;
         cfg_ff.gain_d         <= '0;
         cfg_ff.integral_limit <= ILIM_RESET;
         cfg_ff.dead_zone      <= DZ_RESET;
         cfg_ff.drive_limit    <= DLIM_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> src/pdoc_dp.sv
// PID datapath: deadband, integral and derivative state, three products, clamps.
// Depends on pdoc_pkg.
module pdoc_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   adv,
   input  pdoc_pkg::cfg_type                      cfg,
   input  logic signed [pdoc_pkg::SAMPLE_W-1:0]   sample,
   output logic signed [pdoc_pkg::SAMPLE_W-1:0]   correction
);
   import pdoc_pkg::*;

   localparam int unsigned IW = INTEG_W + 1;     // pre-clamp integral
   localparam int unsigned PW = GAIN_W + SAMPLE_W;
   localparam int unsigned QW = GAIN_W + IW;
   localparam int unsigned DW = GAIN_W + SAMPLE_W + 1;
   localparam int unsigned SW = QW + 2;
   localparam int unsigned YW = SW - 8;

   logic signed [INTEG_W-1:0]  integral_ff;
   logic signed [INTEG_W-1:0]  integral_in;
   logic signed [SAMPLE_W-1:0] last_error_ff;

   logic signed [SAMPLE_W:0]   e_wide;
   logic signed [SAMPLE_W:0]   dz_pos;
   logic signed [SAMPLE_W:0]   dz_neg;
   logic signed [SAMPLE_W-1:0] e;
   logic signed [IW-1:0]       integ;
   logic signed [IW-1:0]       ilim_pos;
   logic signed [IW-1:0]       ilim_neg;
   logic signed [SAMPLE_W:0]   deriv;
   logic signed [PW-1:0]       prod_p;
   logic signed [QW-1:0]       prod_i;
   logic signed [DW-1:0]       prod_d;
   logic signed [SW-1:0]       sum;
   logic signed [SW-1:0]       sum_shr;
   logic signed [YW-1:0]       y;
   logic signed [YW-1:0]       dlim_pos;
   logic signed [YW-1:0]       dlim_neg;

   always_comb begin
      // deadband: zero errors strictly inside plus or minus dead_zone
      e_wide = (SAMPLE_W+1)'(sample);
      dz_pos = $signed({2'b00, cfg.dead_zone});
      dz_neg = -dz_pos;
      if ((e_wide > dz_neg) && (e_wide < dz_pos)) begin
         e = '0;
      end else begin
         e = sample;
      end

      integ = IW'(integral_ff) + IW'(e);
      deriv = (SAMPLE_W+1)'(e) - (SAMPLE_W+1)'(last_error_ff);

      prod_p = cfg.gain_p * e;
      prod_i = cfg.gain_i * integ;
      prod_d = cfg.gain_d * deriv;

      sum     = SW'(prod_p) + SW'(prod_i) + SW'(prod_d);
      sum_shr = sum >>> 8;
      y       = sum_shr[YW-1:0];

      dlim_pos = $signed(YW'({1'b0, cfg.drive_limit}));
      dlim_neg = -dlim_pos;
      priority if (y > dlim_pos) begin
         correction = dlim_pos[SAMPLE_W-1:0];
      end else if (y < dlim_neg) begin
         correction = dlim_neg[SAMPLE_W-1:0];
      end else begin
         correction = y[SAMPLE_W-1:0];
      end

      // anti-windup acts on the stored integral only
      ilim_pos = $signed({2'b00, cfg.integral_limit});
      ilim_neg = -ilim_pos;
      priority if (integ > ilim_pos) begin
         integral_in = ilim_pos[INTEG_W-1:0];
      end else if (integ < ilim_neg) begin
         integral_in = ilim_neg[INTEG_W-1:0];
      end else begin
         integral_in = integ[INTEG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integral_ff   <= '0;
         last_error_ff <= '0;
      end else if (adv) begin
         integral_ff   <= integral_in;
         last_error_ff <= e;
      end
   end

endmodule

>>> src/pid_deadband_output_clamp_top.sv
// PID heading controller with deadband, anti-windup and output clamp: top level.
// Depends on pdoc_pkg, pdoc_csr, pdoc_dp and assert_macros.svh.
//
// One error beat in gives one correction beat out. A beat accepted on req_ lands in an input
// register; when the result register is free or draining, the datapath (deadband, three parallel
// multiplies, sum, floor shift by 8 and saturation) fills the result register from it, and the
// correction then stays valid on rsp_ until it is taken. A new error is taken every cycle while
// rsp_ drains. The stored integral and previous error are updated in the same cycle as the
// result register, which is what sets the one-beat-per-cycle rate: the integral feedback
// closes through the datapath once per beat. Write the csr_ port only while no beat is in
// flight; the register indexes follow the list gain_p, gain_i, gain_d, integral_limit,
// dead_zone, drive_limit, and other indexes are ignored.
`include "assert_macros.svh"

module pid_deadband_output_clamp_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [15:0]                         req_tdata,   // [15:0] error_sample
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [15:0]                         rsp_tdata,   // [15:0] correction
   input  logic                                csr_wr_en,
   input  logic [pdoc_pkg::CSR_AW-1:0]         csr_addr,
   input  logic [pdoc_pkg::CSR_DW-1:0]         csr_wdata
);
   import pdoc_pkg::*;

   cfg_type                    cfg;
   logic                       in_vld_ff;
   logic signed [SAMPLE_W-1:0] in_data_ff;
   logic                       out_vld_ff;
   logic signed [SAMPLE_W-1:0] out_data_ff;
   logic signed [SAMPLE_W-1:0] correction;
   logic                       adv;
   logic                       take;
   logic signed [SAMPLE_W-1:0] drv_lim;

   pdoc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pdoc_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .cfg        (cfg),
      .sample     (in_data_ff),
      .correction (correction)
   );

   // advance the held beat when the result register is free or draining
   assign adv        = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || adv;
   assign take       = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (take) begin
            in_vld_ff <= 1'b1;
         end else if (adv) begin
            in_vld_ff <= 1'b0;
         end
         if (adv) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_data_ff <= $signed(req_tdata[SAMPLE_W-1:0]);
      end
      if (adv) begin
         out_data_ff <= correction;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;

   assign drv_lim = $signed({1'b0, cfg.drive_limit});

   `ASSERT_CLK(a_adv_fills_out, adv |=> out_vld_ff, "advanced beat missing from result register")
   `ASSERT_CLK(a_no_take_when_full, (in_vld_ff && !adv) |-> !req_tready, "input taken while full")
   `ASSERT_CLK(a_out_in_limit, out_vld_ff |-> ((out_data_ff <= drv_lim) && (out_data_ff >= -drv_lim)), "correction beyond drive limit")

endmodule

>>> tb/pid_deadband_output_clamp_top_tb.sv
// Self-checking testbench for the PID controller with deadband, anti-windup and output clamp.
// Depends on pdoc_pkg and pid_deadband_output_clamp_top; a built-in predictor of the controller
// state computes each expected correction beat.
module pid_deadband_output_clamp_top_tb;
   import pdoc_pkg::*;

   localparam logic [CSR_AW-1:0] REG_UNMAPPED_LO = 3'd6;
   localparam logic [CSR_AW-1:0] REG_UNMAPPED_HI = 3'd7;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [15:0]         req_tdata;   // [15:0] error_sample
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [15:0]         rsp_tdata;   // [15:0] correction
   logic                csr_wr_en;
   logic [CSR_AW-1:0]   csr_addr;
   logic [CSR_DW-1:0]   csr_wdata;

   // Controller copy used for prediction
   cfg_type             ctrl_cfg;
   logic signed [23:0]  integ_acc;
   logic signed [15:0]  prev_err;

   logic [15:0]         pending_corrections[$];
   logic [15:0]         oldest_correction;
   int unsigned         fault_count = 0;
   bit                  bubbles_on;
   int unsigned         stall_left = 0;

   pid_deadband_output_clamp_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   // Advance the controller copy by one error sample and return its correction.
   function automatic logic [15:0] predict_correction(input logic [15:0] raw);
      longint e, integ, deriv, total, y, band, ilim, dlim;
      e = longint'($signed(raw));
      band = ctrl_cfg.dead_zone;
      ilim = ctrl_cfg.integral_limit;
      dlim = ctrl_cfg.drive_limit;
      if (e > -band && e < band)
         e = 0;
      // pre-clamp integral, kept wide for the product
      integ = integ_acc + e;
      deriv = e - prev_err;
      prev_err = e[15:0];
      total = $signed(ctrl_cfg.gain_p) * e + $signed(ctrl_cfg.gain_i) * integ
            + $signed(ctrl_cfg.gain_d) * deriv;
      y = total >>> 8;
      if (integ > ilim)
         integ = ilim;
      if (integ < -ilim)
         integ = -ilim;
      integ_acc = integ[23:0];
      if (y > dlim)
         y = dlim;
      if (y < -dlim)
         y = -dlim;
      return y[15:0];
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_corrections.size() == 0) begin
            $error("correction beat with nothing expected: actual %0d", $signed(rsp_tdata));
            fault_count++;
         end else begin
            oldest_correction = pending_corrections.pop_front();
            if (rsp_tdata !== oldest_correction) begin
               $error("correction mismatch: expected %0d actual %0d",
                      $signed(oldest_correction), $signed(rsp_tdata));
               fault_count++;
            end
         end
      end
   end

   // Receiver side: stall in short random bursts while bubbles are on.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else if (bubbles_on && $urandom_range(0, 3) == 0) begin
            rsp_tready = 1'b0;
            stall_left = $urandom_range(1, 4) - 1;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   task automatic send_error(input logic [15:0] sample);
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata = sample;
      do begin
         @(posedge clock);
      end while (!req_tready);
      pending_corrections.push_back(predict_correction(sample));
   endtask

   task automatic pause_sender(input int unsigned cycles);
      @(negedge clock);
      req_tvalid = 1'b0;
      req_tdata = $urandom;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic feed(input logic [15:0] sample);
      if (bubbles_on && $urandom_range(0, 3) == 0)
         pause_sender($urandom_range(1, 4));
      send_error(sample);
   endtask

   // Hold off until every correction is back and the datapath has emptied.
   task automatic drain_pipeline();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_corrections.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_AW-1:0] idx, input logic [CSR_DW-1:0] value);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_addr = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (idx)
         REG_GAIN_P:    ctrl_cfg.gain_p = value[15:0];
         REG_GAIN_I:    ctrl_cfg.gain_i = value[15:0];
         REG_GAIN_D:    ctrl_cfg.gain_d = value[15:0];
         REG_INT_LIMIT: ctrl_cfg.integral_limit = value[22:0];
         REG_DEAD_ZONE: ctrl_cfg.dead_zone = value[14:0];
         REG_DRV_LIMIT: ctrl_cfg.drive_limit = value[14:0];
         default: ;
      endcase
   endtask

   function automatic logic [15:0] pick_gain();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return '0;
         3: return 16'($urandom_range(0, 1023));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_error();
      int v;
      case ($urandom_range(0, 4))
         0: return 16'($urandom);
         1: begin
            // straddle the deadband edge
            v = int'(ctrl_cfg.dead_zone) + $urandom_range(0, 2) - 1;
            return $urandom_range(0, 1) ? 16'(-v) : 16'(v);
         end
         2: begin
            case ($urandom_range(0, 2))
               0: return 16'h7fff;
               1: return 16'h8000;
               default: return '0;
            endcase
         end
         default: begin
            v = $urandom_range(0, 2047);
            return $urandom_range(0, 1) ? 16'(-v) : 16'(v);
         end
      endcase
   endfunction

   task automatic apply_random_settings();
      logic [22:0] ilim;
      logic [14:0] band, dlim;
      case ($urandom_range(0, 3))
         0: ilim = '0;
         1: ilim = ILIM_RESET;
         2: ilim = 23'($urandom_range(0, 65535));
         default: ilim = 23'($urandom_range(0, 8388607));
      endcase
      case ($urandom_range(0, 4))
         0: band = '0;
         1: band = 15'h7fff;
         default: band = 15'($urandom_range(0, 2048));
      endcase
      case ($urandom_range(0, 4))
         0: dlim = '0;
         1: dlim = 15'h7fff;
         default: dlim = 15'($urandom_range(0, 32767));
      endcase
      write_reg(REG_GAIN_P, {7'($urandom), pick_gain()});
      write_reg(REG_GAIN_I, {7'($urandom), pick_gain()});
      write_reg(REG_GAIN_D, {7'($urandom), pick_gain()});
      write_reg(REG_INT_LIMIT, ilim);
      write_reg(REG_DEAD_ZONE, {8'($urandom), band});
      write_reg(REG_DRV_LIMIT, {8'($urandom), dlim});
   endtask

   task automatic test_reset_defaults();
      // zero gains after reset
      feed(16'h7fff);
      feed(16'h8000);
      drain_pipeline();
   endtask

   task automatic test_deadband_edges();
      write_reg(REG_GAIN_P, 23'h000100);
      write_reg(REG_DRV_LIMIT, 23'h007fff);
      feed(16'd127);
      feed(16'd128);
      feed(-16'sd127);
      feed(-16'sd128);
      feed(16'h7fff);
      feed(16'h8000);
      drain_pipeline();
      write_reg(REG_DEAD_ZONE, '0);
      feed(16'h0001);
      feed(16'hffff);
      drain_pipeline();
   endtask

   task automatic test_floor_rounding();
      write_reg(REG_GAIN_P, 23'h000001);
      feed(-16'sd300);
      feed(-16'sd256);
      feed(-16'sd1);
      drain_pipeline();
   endtask

   task automatic test_derivative_extremes();
      write_reg(REG_GAIN_P, '0);
      write_reg(REG_GAIN_D, 23'h008000);
      feed(16'h7fff);
      feed(16'h8000);
      drain_pipeline();
   endtask

   task automatic test_zero_limits();
      write_reg(REG_GAIN_P, 23'h007fff);
      write_reg(REG_GAIN_I, 23'h007fff);
      write_reg(REG_INT_LIMIT, '0);
      write_reg(REG_DRV_LIMIT, '0);
      feed(16'h7fff);
      feed(16'h8000);
      drain_pipeline();
      write_reg(REG_GAIN_P, '0);
      write_reg(REG_GAIN_D, '0);
      write_reg(REG_GAIN_I, 23'h000100);
      write_reg(REG_DRV_LIMIT, 23'h007fff);
      feed(16'd1000);
      feed(16'd1000);
      drain_pipeline();
   endtask

   task automatic test_unmapped_index();
      write_reg(REG_UNMAPPED_LO, '1);
      write_reg(REG_UNMAPPED_HI, '1);
      write_reg(REG_INT_LIMIT, ILIM_RESET);
      feed(16'd3000);
      feed(-16'sd5000);
      drain_pipeline();
   endtask

   task automatic test_random_settings();
      repeat (5) begin
         apply_random_settings();
         repeat (60) feed(pick_error());
         drain_pipeline();
      end
   endtask

   // Push the integral to one bound so the pre-clamp sum runs past 24 bits.
   task automatic test_integral_windup(input bit upward);
      int mag;
      write_reg(REG_INT_LIMIT, '0);
      feed('0);
      drain_pipeline();
      write_reg(REG_INT_LIMIT, ILIM_RESET);
      write_reg(REG_GAIN_P, {7'($urandom), pick_gain()});
      write_reg(REG_GAIN_I, {7'($urandom), pick_gain()});
      write_reg(REG_GAIN_D, {7'($urandom), pick_gain()});
      write_reg(REG_DEAD_ZONE, 23'($urandom_range(0, 256)));
      write_reg(REG_DRV_LIMIT, 23'($urandom_range(0, 32767)));
      repeat (320) begin
         if ($urandom_range(0, 9) == 0) begin
            feed(16'($urandom));
         end else begin
            mag = $urandom_range(31000, 32767);
            feed(upward ? 16'(mag) : 16'(-mag));
         end
      end
      drain_pipeline();
   endtask

   task automatic test_steady_stream();
      apply_random_settings();
      repeat (80) feed(pick_error());
      drain_pipeline();
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_wr_en = 1'b0;
      csr_addr = REG_GAIN_P;
      csr_wdata = '0;
      bubbles_on = 1'b1;
      ctrl_cfg = '{gain_p: '0, gain_i: '0, gain_d: '0, integral_limit: ILIM_RESET,
                   dead_zone: DZ_RESET, drive_limit: DLIM_RESET};
      integ_acc = '0;
      prev_err = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_deadband_edges();
      test_floor_rounding();
      test_derivative_extremes();
      test_zero_limits();
      test_unmapped_index();
      test_random_settings();
      test_integral_windup(1'b1);
      test_integral_windup(1'b0);
      bubbles_on = 1'b0;
      test_steady_stream();

      if (fault_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

>>> sim.f
+incdir+src
src/pdoc_pkg.sv
src/pdoc_csr.sv
src/pdoc_dp.sv
src/pid_deadband_output_clamp_top.sv
tb/pid_deadband_output_clamp_top_tb.sv
